### hw/rtl/tdm_pkg.sv
// Shared constants for the trough detector with merge.
// Register widths, register map and result buffer sizing; no dependencies.
`timescale 1ns / 1ps

package tdm_pkg;

  // Configuration register widths
  localparam int WL_BITS  = 6;
  localparam int MD_BITS  = 20;
  localparam int THR_BITS = 16;

  // Configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_WINDOW_LENGTH    = 2'd0;
  localparam logic [1:0] REG_MERGE_DISTANCE   = 2'd1;
  localparam logic [1:0] REG_TROUGH_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [WL_BITS-1:0]  WINDOW_LENGTH_RST    = 6'd4;
  localparam logic [MD_BITS-1:0]  MERGE_DISTANCE_RST   = 20'd0;
  localparam logic [THR_BITS-1:0] TROUGH_THRESHOLD_RST = 16'd0;

  // Result buffer: one item can produce two results
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = 2;
  localparam int LEVEL_BITS = 3;

endpackage

### hw/rtl/tdm_window.sv
// Sample history shift line, backward window compare and sample index counter.
// Depends on tdm_pkg for the window length register width.
`timescale 1ns / 1ps

module tdm_window #(
  parameter int WINDOW_MAX  = 32,
  parameter int INDEX_BITS  = 20,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          last,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [tdm_pkg::WL_BITS-1:0]   window_length,
  input  logic signed [SAMPLE_BITS-1:0] threshold,
  output logic                          trough,
  output logic [INDEX_BITS-1:0]         index
);

  localparam int HIST_DEPTH = WINDOW_MAX - 1;
  localparam int WLC_FULL   = $clog2(WINDOW_MAX + 1);
  localparam int WLC_BITS   = (WLC_FULL > tdm_pkg::WL_BITS) ? tdm_pkg::WL_BITS : WLC_FULL;

  logic signed [SAMPLE_BITS-1:0] history [HIST_DEPTH];
  logic [WLC_BITS-1:0]           wl_eff;
  logic [HIST_DEPTH-1:0]         lane_ok;
  logic                          index_ok;

  // clamp an oversized window to the history depth plus the current sample
  assign wl_eff = (32'(window_length) > 32'(WINDOW_MAX)) ? WLC_BITS'(WINDOW_MAX)
                                                         : WLC_BITS'(window_length);

  // lanes beyond the window pass unconditionally
  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_lane
    assign lane_ok[k] = (32'(k + 1) >= 32'(wl_eff)) || (sample <= history[k]);
  end

  assign index_ok = ({1'b0, index} >= (INDEX_BITS + 1)'(wl_eff));
  assign trough   = index_ok && (&lane_ok) && (sample <= threshold);

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        history[k] <= '0;
      end
    end else if (accept) begin
      history[0] <= sample;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        history[k] <= history[k-1];
      end
    end
  end

  // saturate at all ones
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      index <= '0;
    end else if (accept && (index != '1)) begin
      index <= index + INDEX_BITS'(1);
    end
  end

endmodule

### hw/rtl/tdm_merge.sv
// Pending trough register, merge test and result formation (up to two per sample).
// Depends on tdm_pkg for the merge distance width.
`timescale 1ns / 1ps

module tdm_merge #(
  parameter int INDEX_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        last,
  input  logic                        trough,
  input  logic [INDEX_BITS-1:0]       index,
  input  logic [tdm_pkg::MD_BITS-1:0] merge_distance,
  output logic [1:0]                  push_cnt,
  output logic [INDEX_BITS+1:0]       push_a,
  output logic [INDEX_BITS+1:0]       push_b
);

  localparam int SUM_BITS =
    ((INDEX_BITS > tdm_pkg::MD_BITS) ? INDEX_BITS : tdm_pkg::MD_BITS) + 1;

  logic [INDEX_BITS-1:0] pending_index;
  logic                  pending_valid;
  logic                  merge_hit;
  logic                  emit_old;
  logic                  pv_after;
  logic [INDEX_BITS-1:0] pi_after;
  logic [INDEX_BITS+1:0] entry_old;
  logic [INDEX_BITS+1:0] entry_end;

  // compare without wrap-around
  assign merge_hit = pending_valid &&
                     (SUM_BITS'(index) <= SUM_BITS'(pending_index) + SUM_BITS'(merge_distance));
  assign emit_old  = trough && pending_valid && !merge_hit;
  assign pv_after  = pending_valid || trough;
  assign pi_after  = trough ? index : pending_index;

  // entry layout from the lowest bit: index, index valid, end of stream
  assign entry_old = {1'b0, 1'b1, pending_index};
  assign entry_end = {1'b1, pv_after, pv_after ? pi_after : '0};

  assign push_a   = emit_old ? entry_old : entry_end;
  assign push_b   = entry_end;
  assign push_cnt = accept ? (2'(emit_old) + 2'(last)) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      pending_valid <= 1'b0;
      pending_index <= '0;
    end else if (accept && trough) begin
      pending_valid <= 1'b1;
      pending_index <= index;
    end
  end

endmodule

### hw/rtl/tdm_result_fifo.sv
// Small result buffer taking zero, one or two entries per cycle, one out per transfer.
// Depends on tdm_pkg for depth, pointer and level widths.
`timescale 1ns / 1ps

module tdm_result_fifo #(
  parameter int ENTRY_BITS = 22
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [1:0]                     push_cnt,
  input  logic [ENTRY_BITS-1:0]          push_a,
  input  logic [ENTRY_BITS-1:0]          push_b,
  input  logic                           pop,
  output logic                           out_valid,
  output logic [ENTRY_BITS-1:0]          out_entry,
  output logic [tdm_pkg::LEVEL_BITS-1:0] level
);

  logic [ENTRY_BITS-1:0]               mem [tdm_pkg::FIFO_DEPTH];
  logic [tdm_pkg::PTR_BITS-1:0]        wr_ptr;
  logic [tdm_pkg::PTR_BITS-1:0]        rd_ptr;
  logic [tdm_pkg::PTR_BITS-1:0]        wr_ptr_b;
  logic [tdm_pkg::LEVEL_BITS-1:0]      level_next;

  assign wr_ptr_b   = wr_ptr + tdm_pkg::PTR_BITS'(1);
  assign out_valid  = (level != '0);
  assign out_entry  = mem[rd_ptr];
  assign level_next = level + tdm_pkg::LEVEL_BITS'(push_cnt)
                      - tdm_pkg::LEVEL_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_b] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tdm_pkg::PTR_BITS'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + tdm_pkg::PTR_BITS'(1);
      end
      level <= level_next;
    end
  end

endmodule

### hw/rtl/trough_detector_with_merge_unit.sv
// Top level of the trough detector with merge: stream ports, APB registers.
// Depends on tdm_pkg, tdm_window, tdm_merge and tdm_result_fifo.
`timescale 1ns / 1ps

// Usage
//   Samples enter on the s_ channel, one per transfer, s_tlast on the final
//   sample of a stream. Each sample is judged against the previous
//   window_length-1 samples and the threshold in the cycle it is accepted;
//   troughs within merge_distance of the pending one replace it.
//   Results leave on the m_ channel: trough index in m_tdata, index valid in
//   m_tuser, end of stream in m_tlast. A sample yields zero, one or two
//   results; the final sample always yields one or two.
//   Results are registered in the result buffer as their samples are accepted.
//   Throughput: one sample per cycle while s_tready is high; the window
//   compare is a parallel reduction over the registered history. A four-entry
//   result buffer sits between the sides; s_tready drops only while it holds
//   three or more results, i.e. when the receiver stalls.
//   Reset clears the history, sample index, pending trough and buffer, and
//   loads the register defaults (window 4, merge distance 0, threshold 0).
//   Write registers only while the block is idle.
module trough_detector_with_merge_unit #(
  parameter int WINDOW_MAX  = 32,
  parameter int INDEX_BITS  = 20,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // stream in
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                                 s_tlast,   // last_sample
  // stream out
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((INDEX_BITS+7)/8)*8-1:0]      m_tdata,   // [INDEX_BITS-1:0] trough_index
  output logic                                 m_tuser,   // index_valid
  output logic                                 m_tlast,   // end_of_stream
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tdm_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [tdm_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [tdm_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);

  localparam int OUT_TDATA_BITS = ((INDEX_BITS + 7) / 8) * 8;
  localparam int ENTRY_BITS     = INDEX_BITS + 2;

  logic [tdm_pkg::WL_BITS-1:0]         window_length;
  logic [tdm_pkg::MD_BITS-1:0]         merge_distance;
  logic signed [tdm_pkg::THR_BITS-1:0] trough_threshold;

  logic                          cfg_write;
  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] threshold;
  logic                          trough;
  logic [INDEX_BITS-1:0]         index;
  logic [1:0]                    push_cnt;
  logic [ENTRY_BITS-1:0]         push_a;
  logic [ENTRY_BITS-1:0]         push_b;
  logic [ENTRY_BITS-1:0]         out_entry;
  logic [tdm_pkg::LEVEL_BITS-1:0] level;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= tdm_pkg::WINDOW_LENGTH_RST;
      merge_distance   <= tdm_pkg::MERGE_DISTANCE_RST;
      trough_threshold <= tdm_pkg::TROUGH_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        tdm_pkg::REG_WINDOW_LENGTH:    window_length    <= pwdata[tdm_pkg::WL_BITS-1:0];
        tdm_pkg::REG_MERGE_DISTANCE:   merge_distance   <= pwdata[tdm_pkg::MD_BITS-1:0];
        tdm_pkg::REG_TROUGH_THRESHOLD: trough_threshold <= pwdata[tdm_pkg::THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tdm_pkg::REG_WINDOW_LENGTH:    prdata = tdm_pkg::APB_DATA_BITS'(window_length);
      tdm_pkg::REG_MERGE_DISTANCE:   prdata = tdm_pkg::APB_DATA_BITS'(merge_distance);
      tdm_pkg::REG_TROUGH_THRESHOLD:
        prdata = tdm_pkg::APB_DATA_BITS'($unsigned(trough_threshold));
      default:                       prdata = '0;
    endcase
  end

  // input side
  assign accept    = s_tvalid && s_tready;
  assign sample    = $signed(s_tdata[SAMPLE_BITS-1:0]);
  assign threshold = SAMPLE_BITS'(trough_threshold);
  assign s_tready  = (level <= tdm_pkg::LEVEL_BITS'(tdm_pkg::FIFO_DEPTH - 2));

  tdm_window #(
    .WINDOW_MAX  (WINDOW_MAX),
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .last          (s_tlast),
    .sample        (sample),
    .window_length (window_length),
    .threshold     (threshold),
    .trough        (trough),
    .index         (index)
  );

  tdm_merge #(
    .INDEX_BITS (INDEX_BITS)
  ) u_merge (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .last           (s_tlast),
    .trough         (trough),
    .index          (index),
    .merge_distance (merge_distance),
    .push_cnt       (push_cnt),
    .push_a         (push_a),
    .push_b         (push_b)
  );

  tdm_result_fifo #(
    .ENTRY_BITS (ENTRY_BITS)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push_a    (push_a),
    .push_b    (push_b),
    .pop       (m_tvalid && m_tready),
    .out_valid (m_tvalid),
    .out_entry (out_entry),
    .level     (level)
  );

  // output side
  assign m_tdata = OUT_TDATA_BITS'(out_entry[INDEX_BITS-1:0]);
  assign m_tuser = out_entry[INDEX_BITS];
  assign m_tlast = out_entry[INDEX_BITS+1];

  // the final sample of a stream always leaves a result behind
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("no result after final sample");

  // buffer never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= tdm_pkg::LEVEL_BITS'(tdm_pkg::FIFO_DEPTH))
    else $error("result buffer overflow");

  // an empty buffer never holds off the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result buffer");

endmodule
